// File: hdl/ezyx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezyx_pkg: shared types and constants for the Euler ZYX transform core
// CORDIC constants in Q30, angle table and the per-cell data word.
// ----------------------------------------------------------------------------
package ezyx_pkg;

  localparam int AngleBits  = 16;
  localparam int TrigStages = 16;
  localparam int TabLen     = 24;
  localparam int FracInt    = 30;
  localparam int AngShift   = FracInt - (AngleBits - 3);

  // CORDIC datapath width: angles up to 4 rad in Q30 plus growth
  localparam int CW = 35;

  localparam logic signed [CW-1:0] GainQ30   = 35'sd652032874;
  localparam logic signed [CW-1:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [CW-1:0] PiQ30     = 35'sd3373259426;

  // truncated atan(2^-i) in Q30
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic [31:0] v;
    begin
      unique case (i)
        0:  v = 32'h3243F6A8;  1:  v = 32'h1DAC6705;  2:  v = 32'h0FADBAFC;
        3:  v = 32'h07F56EA6;  4:  v = 32'h03FEAB76;  5:  v = 32'h01FFD55B;
        6:  v = 32'h00FFFAAA;  7:  v = 32'h007FFF55;  8:  v = 32'h003FFFEA;
        9:  v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF;  16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
        18: v = 32'h00000FFF;  19: v = 32'h000007FF;  20: v = 32'h000003FF;
        21: v = 32'h000001FF;  22: v = 32'h000000FF;  default: v = 32'h0000007F;
      endcase
      atan_q30 = CW'(signed'({1'b0, v}));
    end
  endfunction

  // state of one angle's CORDIC in flight
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } rot_t;

  // one word in flight through the cell row
  typedef struct packed {
    logic               vld;
    rot_t [2:0]         ang;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } cell_word_t;

endpackage

// File: hdl/ezyx_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezyx_cell: one CORDIC iteration for the three angles
// Shift amount and table entry fixed by the cell's place in the row.
// ----------------------------------------------------------------------------
module ezyx_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [4:0]           stage,
  input  ezyx_pkg::cell_word_t w_in,
  output ezyx_pkg::cell_word_t w_out_r
);

  logic signed [ezyx_pkg::CW-1:0] atan_v;
  ezyx_pkg::cell_word_t w_nxt;

  // stage is tied to a constant, so this folds to one table entry
  assign atan_v = ezyx_pkg::atan_q30(int'(stage));

  // micro-rotation toward zero residual angle
  always_comb begin
    w_nxt = w_in;
    w_nxt.vld = w_in.vld & rst_n;
    for (int a = 0; a < 3; a++) begin
      if (!w_in.ang[a].z[ezyx_pkg::CW-1]) begin
        w_nxt.ang[a].x = w_in.ang[a].x - (w_in.ang[a].y >>> stage);
        w_nxt.ang[a].y = w_in.ang[a].y + (w_in.ang[a].x >>> stage);
        w_nxt.ang[a].z = w_in.ang[a].z - atan_v;
      end else begin
        w_nxt.ang[a].x = w_in.ang[a].x + (w_in.ang[a].y >>> stage);
        w_nxt.ang[a].y = w_in.ang[a].y - (w_in.ang[a].x >>> stage);
        w_nxt.ang[a].z = w_in.ang[a].z + atan_v;
      end
    end
  end

  // valid bit is cleared through w_nxt while in reset
  always_ff @(posedge clk) begin
    w_out_r <= w_nxt;
  end

endmodule

// File: hdl/ezyx_mat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezyx_mat: trig rounding and rotation matrix assembly
// Four register stages: round/clamp, first products, second products, Q14.
// ----------------------------------------------------------------------------
module ezyx_mat (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ezyx_pkg::cell_word_t w_in,
  output logic                 vld_r,
  output logic [8:0][15:0]     rot_r,
  output logic signed [31:0]   dx_r,
  output logic signed [31:0]   dy_r,
  output logic signed [31:0]   dz_r
);

  // Q30 cordic value to clamped Q16
  function automatic logic signed [17:0] to_q16(input logic signed [ezyx_pkg::CW-1:0] v,
                                                input logic flip);
    logic signed [ezyx_pkg::CW:0] t;
    logic signed [ezyx_pkg::CW:0] r;
    begin
      t = flip ? -(ezyx_pkg::CW+1)'(v) : (ezyx_pkg::CW+1)'(v);
      r = (t + (ezyx_pkg::CW+1)'(8192)) >>> 14;
      if (r > 65536) to_q16 = 18'sd65536;
      else if (r < -65536) to_q16 = -18'sd65536;
      else to_q16 = r[17:0];
    end
  endfunction

  // Q48 to clamped Q14
  function automatic logic [15:0] to_q14(input logic signed [51:0] v);
    logic signed [51:0] r;
    begin
      r = (v + 52'sd8589934592) >>> 34;
      if (r > 16384) to_q14 = 16'h4000;
      else if (r < -16384) to_q14 = 16'hC000;
      else to_q14 = r[15:0];
    end
  endfunction

  logic signed [17:0] sx_r, cx_r, sy_r, cy_r, sz_r, cz_r;
  logic               v1_r, v2_r, v3_r;
  logic signed [31:0] d1x_r, d1y_r, d1z_r, d2x_r, d2y_r, d2z_r, d3x_r, d3y_r, d3z_r;
  // stage 2 products (Q32)
  logic signed [35:0] czcy_r, szcy_r, sysx_r, sycx_r, szcx_r, szsx_r, czcx_r, czsx_r;
  logic signed [35:0] cysx_r, cycx_r, sy2_r;
  logic signed [17:0] cz2_r, sz2_r;
  // stage 3 sums (Q48)
  logic signed [51:0] e_r [9];

  always_ff @(posedge clk) begin
    // stage 1: trig values
    cx_r <= to_q16(w_in.ang[0].x, w_in.ang[0].flip);
    sx_r <= to_q16(w_in.ang[0].y, w_in.ang[0].flip);
    cy_r <= to_q16(w_in.ang[1].x, w_in.ang[1].flip);
    sy_r <= to_q16(w_in.ang[1].y, w_in.ang[1].flip);
    cz_r <= to_q16(w_in.ang[2].x, w_in.ang[2].flip);
    sz_r <= to_q16(w_in.ang[2].y, w_in.ang[2].flip);
    d1x_r <= w_in.dx; d1y_r <= w_in.dy; d1z_r <= w_in.dz;
    // stage 2: pair products
    czcy_r <= cz_r * cy_r;  szcy_r <= sz_r * cy_r;
    sysx_r <= sy_r * sx_r;  sycx_r <= sy_r * cx_r;
    szcx_r <= sz_r * cx_r;  szsx_r <= sz_r * sx_r;
    czcx_r <= cz_r * cx_r;  czsx_r <= cz_r * sx_r;
    cysx_r <= cy_r * sx_r;  cycx_r <= cy_r * cx_r;
    sy2_r  <= 36'(sy_r);
    cz2_r <= cz_r; sz2_r <= sz_r;
    d2x_r <= d1x_r; d2y_r <= d1y_r; d2z_r <= d1z_r;
    // stage 3: Q48 entries
    e_r[0] <= 52'(czcy_r) <<< 16;
    e_r[1] <= 52'(cz2_r * sysx_r) - (52'(szcx_r) <<< 16);
    e_r[2] <= 52'(cz2_r * sycx_r) + (52'(szsx_r) <<< 16);
    e_r[3] <= 52'(szcy_r) <<< 16;
    e_r[4] <= 52'(sz2_r * sysx_r) + (52'(czcx_r) <<< 16);
    e_r[5] <= 52'(sz2_r * sycx_r) - (52'(czsx_r) <<< 16);
    e_r[6] <= -(52'(sy2_r) <<< 32);
    e_r[7] <= 52'(cysx_r) <<< 16;
    e_r[8] <= 52'(cycx_r) <<< 16;
    d3x_r <= d2x_r; d3y_r <= d2y_r; d3z_r <= d2z_r;
    // stage 4: round to Q14
    for (int k = 0; k < 9; k++) rot_r[k] <= to_q14(e_r[k]);
    dx_r <= d3x_r; dy_r <= d3y_r; dz_r <= d3z_r;
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; vld_r <= 1'b0;
    end else begin
      v1_r <= w_in.vld; v2_r <= v1_r; v3_r <= v2_r; vld_r <= v3_r;
    end
  end

endmodule

// File: hdl/euler_zyx_homogeneous_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zyx_homogeneous_transform_core: Euler ZYX angles to 3x4 transform
// Fully pipelined: one word per cycle, through one input register, one cell
// per CORDIC iteration and four matrix stages, the last of which drives the
// result ports. busy is never asserted; every word started yields one
// result on out_valid.
// The receiver cannot stall, so results must be taken when shown.
// ----------------------------------------------------------------------------
module euler_zyx_homogeneous_transform_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [ezyx_pkg::AngleBits-1:0] in_angle_x,
  input  logic signed [ezyx_pkg::AngleBits-1:0] in_angle_y,
  input  logic signed [ezyx_pkg::AngleBits-1:0] in_angle_z,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  output logic               out_valid,
  output logic signed [15:0] out_rot_00,
  output logic signed [15:0] out_rot_01,
  output logic signed [15:0] out_rot_02,
  output logic signed [15:0] out_rot_10,
  output logic signed [15:0] out_rot_11,
  output logic signed [15:0] out_rot_12,
  output logic signed [15:0] out_rot_20,
  output logic signed [15:0] out_rot_21,
  output logic signed [15:0] out_rot_22,
  output logic signed [31:0] out_shift_x,
  output logic signed [31:0] out_shift_y,
  output logic signed [31:0] out_shift_z
);

  localparam int N = ezyx_pkg::TrigStages;

  ezyx_pkg::cell_word_t head_r, head_nxt;
  ezyx_pkg::cell_word_t row [N+1];

  // range reduction into the CORDIC start state
  function automatic ezyx_pkg::rot_t seed(input logic signed [ezyx_pkg::AngleBits-1:0] a);
    ezyx_pkg::rot_t s;
    logic signed [ezyx_pkg::CW-1:0] z;
    begin
      z = ezyx_pkg::CW'(a) <<< ezyx_pkg::AngShift;
      s.flip = 1'b0;
      if (z > ezyx_pkg::HalfPiQ30) begin
        z = z - ezyx_pkg::PiQ30; s.flip = 1'b1;
      end else if (z < -ezyx_pkg::HalfPiQ30) begin
        z = z + ezyx_pkg::PiQ30; s.flip = 1'b1;
      end
      s.x = ezyx_pkg::GainQ30;
      s.y = '0;
      s.z = z;
      seed = s;
    end
  endfunction

  // saturating difference
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] b,
                                                 input logic signed [31:0] a);
    logic signed [32:0] d;
    begin
      d = 33'(b) - 33'(a);
      if (d > 33'sd2147483647) sat_sub = 32'h7FFFFFFF;
      else if (d < -33'sd2147483648) sat_sub = 32'h80000000;
      else sat_sub = d[31:0];
    end
  endfunction

  assign busy = 1'b0;

  always_comb begin
    head_nxt.vld    = start & rst_n;
    head_nxt.ang[0] = seed(in_angle_x);
    head_nxt.ang[1] = seed(in_angle_y);
    head_nxt.ang[2] = seed(in_angle_z);
    head_nxt.dx     = sat_sub(in_target_x, in_origin_x);
    head_nxt.dy     = sat_sub(in_target_y, in_origin_y);
    head_nxt.dz     = sat_sub(in_target_z, in_origin_z);
  end

  // input register; valid cleared through head_nxt in reset
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

  assign row[0] = head_r;

  // row of CORDIC cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    ezyx_cell u_cell (
      .clk(clk), .rst_n(rst_n), .stage(5'(g)), .w_in(row[g]), .w_out_r(row[g+1])
    );
  end

  logic [8:0][15:0]   rot;
  logic signed [31:0] sx, sy, sz;

  ezyx_mat u_mat (
    .clk(clk), .rst_n(rst_n), .w_in(row[N]),
    .vld_r(out_valid), .rot_r(rot), .dx_r(sx), .dy_r(sy), .dz_r(sz)
  );

  assign out_rot_00 = rot[0];
  assign out_rot_01 = rot[1];
  assign out_rot_02 = rot[2];
  assign out_rot_10 = rot[3];
  assign out_rot_11 = rot[4];
  assign out_rot_12 = rot[5];
  assign out_rot_20 = rot[6];
  assign out_rot_21 = rot[7];
  assign out_rot_22 = rot[8];
  assign out_shift_x = sx;
  assign out_shift_y = sy;
  assign out_shift_z = sz;

endmodule

// File: hdl/ezyx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezyx_checker: port-level checks for the transform core
// Busy, latency and entry range.
// ----------------------------------------------------------------------------
module ezyx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_rot_00,
  input logic signed [15:0] out_rot_22,
  input logic signed [15:0] out_rot_20
);

  localparam int Lat = ezyx_pkg::TrigStages + 5;

  // core never holds off a word
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");

  // each start yields a result a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##Lat out_valid) else $error("result missing");

  // entries 00, 22 and 20 stay within +-1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rot_00 <= 16'sd16384 && out_rot_00 >= -16'sd16384 &&
                   out_rot_22 <= 16'sd16384 && out_rot_22 >= -16'sd16384 &&
                   out_rot_20 <= 16'sd16384 && out_rot_20 >= -16'sd16384))
    else $error("rotation entry out of range");

endmodule

bind euler_zyx_homogeneous_transform_core ezyx_checker u_ezyx_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_rot_00(out_rot_00), .out_rot_22(out_rot_22), .out_rot_20(out_rot_20)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for euler_zyx_homogeneous_transform_core
// Drives angle/point words with random gaps, predicts the rotation entries
// and saturated translation in software, and compares every result word.
// ----------------------------------------------------------------------------

// pose word going in, transform word coming out
typedef struct {
  logic signed [15:0] ax, ay, az;
  logic signed [31:0] ox, oy, oz, tx, ty, tz;
} pose_word_t;

typedef struct {
  logic signed [15:0] r [9];
  logic signed [31:0] s [3];
} xform_word_t;

class xform_scoreboard;
  xform_word_t pending [$];
  int          mismatches = 0;

  static function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  static function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // sine/cosine in Q16 via rotation-mode CORDIC
  static function automatic void sincos(logic signed [15:0] a,
                                        output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit     neg;
    z   = longint'(a) <<< (ezyx_pkg::FracInt - (ezyx_pkg::AngleBits - 3));
    x   = 652032874;
    y   = 0;
    neg = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; neg = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; neg = 1;
    end
    for (int i = 0; i < ezyx_pkg::TrigStages; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ezyx_pkg::atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(ezyx_pkg::atan_q30(i));
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = clip(fshift(x + (64'sd1 <<< 13), 14), -65536, 65536);
    s = clip(fshift(y + (64'sd1 <<< 13), 14), -65536, 65536);
  endfunction

  static function automatic logic signed [15:0] q14(longint v);
    return 16'(clip(fshift(v + (64'sd1 <<< 33), 34), -16384, 16384));
  endfunction

  static function automatic logic signed [31:0] sub_sat(logic signed [31:0] b,
                                                       logic signed [31:0] a);
    return 32'(clip(longint'(b) - longint'(a), -64'sd2147483648, 64'sd2147483647));
  endfunction

  function void note_pose(pose_word_t p);
    longint sx, cx, sy, cy, sz, cz;
    longint k;
    xform_word_t e;
    k = 65536;
    sincos(p.ax, sx, cx);
    sincos(p.ay, sy, cy);
    sincos(p.az, sz, cz);
    e.r[0] = q14(cz * cy * k);
    e.r[1] = q14(cz * sy * sx - sz * cx * k);
    e.r[2] = q14(cz * sy * cx + sz * sx * k);
    e.r[3] = q14(sz * cy * k);
    e.r[4] = q14(sz * sy * sx + cz * cx * k);
    e.r[5] = q14(sz * sy * cx - cz * sx * k);
    e.r[6] = q14(-sy * k * k);
    e.r[7] = q14(cy * sx * k);
    e.r[8] = q14(cy * cx * k);
    e.s[0] = sub_sat(p.tx, p.ox);
    e.s[1] = sub_sat(p.ty, p.oy);
    e.s[2] = sub_sat(p.tz, p.oz);
    pending.push_back(e);
  endfunction

  function void check_xform(xform_word_t got);
    xform_word_t e;
    bit bad;
    bad = 0;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word");
      return;
    end
    e = pending.pop_front();
    for (int i = 0; i < 9; i++)
      if (got.r[i] !== e.r[i]) begin
        bad = 1;
        if (mismatches < 10)
          $display("rot[%0d]: expected %0d got %0d", i, e.r[i], got.r[i]);
      end
    for (int i = 0; i < 3; i++)
      if (got.s[i] !== e.s[i]) begin
        bad = 1;
        if (mismatches < 10)
          $display("shift[%0d]: expected %0d got %0d", i, e.s[i], got.s[i]);
      end
    if (bad) mismatches++;
  endfunction
endclass

module testbench;
  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid;
  logic signed [15:0] in_angle_x = 0, in_angle_y = 0, in_angle_z = 0;
  logic signed [31:0] in_origin_x = 0, in_origin_y = 0, in_origin_z = 0;
  logic signed [31:0] in_target_x = 0, in_target_y = 0, in_target_z = 0;
  logic signed [15:0] out_rot_00, out_rot_01, out_rot_02, out_rot_10, out_rot_11;
  logic signed [15:0] out_rot_12, out_rot_20, out_rot_21, out_rot_22;
  logic signed [31:0] out_shift_x, out_shift_y, out_shift_z;

  xform_scoreboard board = new();

  euler_zyx_homogeneous_transform_core uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // check result words as they pass
  always @(posedge clk) begin
    xform_word_t got;
    if (rst_n && out_valid) begin
      got.r = '{out_rot_00, out_rot_01, out_rot_02, out_rot_10, out_rot_11,
                out_rot_12, out_rot_20, out_rot_21, out_rot_22};
      got.s = '{out_shift_x, out_shift_y, out_shift_z};
      board.check_xform(got);
    end
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'sd25736 - 16'($urandom_range(0, 40));
      1: return -16'sd25736 + 16'($urandom_range(0, 40));
      2: return 16'($urandom_range(0, 2 * 12868)) - 16'sd12868;
      3: return 16'($urandom_range(0, 2 * 32767)) - 16'sd32767;
      default: return 16'($urandom_range(0, 2 * 25736)) - 16'sd25736;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed(16'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  // one word: gap, present, wait for acceptance; start stays up for the next
  task automatic send_pose(pose_word_t p);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1;
    in_angle_x  <= p.ax; in_angle_y  <= p.ay; in_angle_z  <= p.az;
    in_origin_x <= p.ox; in_origin_y <= p.oy; in_origin_z <= p.oz;
    in_target_x <= p.tx; in_target_y <= p.ty; in_target_z <= p.tz;
    do @(posedge clk); while (busy);
    board.note_pose(p);
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    pose_word_t p;
    logic signed [15:0] ang [12];
    ang = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
            16'sd12869, -16'sd12869, 16'sd25735, 16'sd32767, -16'sd32768,
            16'sd6434, 16'sd1};
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: angle extremes around +-pi/2 and +-pi, translation overflow
    for (int i = 0; i < 12; i++) begin
      p.ax = ang[i]; p.ay = ang[(i + 3) % 12]; p.az = ang[(i + 7) % 12];
      p.ox = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      p.tx = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      p.oy = 32'sd1; p.ty = 32'h8000_0000;
      p.oz = -32'sd1; p.tz = 32'h7FFF_FFFF;
      send_pose(p);
    end
    p = '{16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0};
    send_pose(p);
    p = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_pose(p);
    // pause until the pipeline is empty
    drain();
    for (int n = 0; n < 1000; n++) begin
      p.ax = rand_angle(); p.ay = rand_angle(); p.az = rand_angle();
      p.ox = rand_coord(); p.oy = rand_coord(); p.oz = rand_coord();
      p.tx = rand_coord(); p.ty = rand_coord(); p.tz = rand_coord();
      send_pose(p);
      if (n == 500) drain();
    end
    drain();
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #500000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
